FILE: design/esu_pkg.sv
// Package: escape decoder codes, character constants, item types and UTF-8 helpers.
`timescale 1ns / 1ps
package esu_pkg;

  localparam logic [2:0] MODE_TEXT = 3'd0;
  localparam logic [2:0] MODE_ESC  = 3'd1;
  localparam logic [2:0] MODE_OCT  = 3'd2;
  localparam logic [2:0] MODE_X    = 3'd3;
  localparam logic [2:0] MODE_U4   = 3'd4;
  localparam logic [2:0] MODE_U8   = 3'd5;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_UC_U   = 8'h55;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_UC_F_A = 8'h61;
  localparam logic [7:0] CH_LC_F_F = 8'h66;

  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_VT  = 8'h0B;
  localparam logic [7:0] CTL_BEL = 8'h07;

  localparam logic [31:0] CP_LIM1 = 32'h80;
  localparam logic [31:0] CP_LIM2 = 32'h800;
  localparam logic [31:0] CP_LIM3 = 32'h10000;
  localparam logic [31:0] CP_LIM4 = 32'h110000;

  localparam logic [3:0] MAXD_OCT = 4'd3;
  localparam logic [3:0] MAXD_X   = 4'd2;
  localparam logic [3:0] MAXD_U4  = 4'd4;
  localparam logic [3:0] MAXD_U8  = 4'd8;

  localparam int unsigned RUN_MAX = 5;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [2:0]              cnt;
    logic                    last;
  } run_t;

  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
  } utf8_t;

  typedef struct packed {
    logic        en;
    logic [31:0] cp;
  } pend_t;

  typedef struct packed {
    logic ok;
    logic [3:0] val;
  } digit_t;

  function automatic utf8_t utf8_enc(input logic [31:0] cp);
    utf8_t r;
    r = '0;
    if (cp < CP_LIM1) begin
      r.cnt = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < CP_LIM2) begin
      r.cnt = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < CP_LIM3) begin
      r.cnt = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else if (cp < CP_LIM4) begin
      r.cnt = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  function automatic digit_t hex_decode(input logic [7:0] b);
    digit_t d;
    d = '0;
    if (b >= CH_0 && b <= CH_9) begin
      d.ok = 1'b1;
      d.val = 4'(b - CH_0);
    end else if (b >= CH_UC_A && b <= CH_UC_F) begin
      d.ok = 1'b1;
      d.val = 4'(b - CH_UC_A + 8'd10);
    end else if (b >= CH_UC_F_A && b <= CH_LC_F_F) begin
      d.ok = 1'b1;
      d.val = 4'(b - CH_UC_F_A + 8'd10);
    end
    return d;
  endfunction

  // What a pending numeric escape stands for when it is cut short.
  function automatic pend_t pending_point(input logic [2:0] mode, input logic [3:0] cnt,
                                          input logic [31:0] acc);
    pend_t p;
    p = '0;
    if (cnt != 4'd0) begin
      p.en = 1'b1;
      p.cp = acc;
    end else if (mode == MODE_X) begin
      p.en = 1'b1;
      p.cp = {24'd0, CH_LC_X};
    end else if (mode == MODE_U4) begin
      p.en = 1'b1;
      p.cp = {24'd0, CH_LC_U};
    end else if (mode == MODE_U8) begin
      p.en = 1'b1;
      p.cp = {24'd0, CH_UC_U};
    end
    return p;
  endfunction

  function automatic logic is_numeric(input logic [2:0] mode);
    return mode >= MODE_OCT && mode <= MODE_U8;
  endfunction

endpackage

FILE: design/esu_if.sv
// Interfaces: input byte channel and result channel.
`timescale 1ns / 1ps
interface esu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface esu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       run_last;
  logic       end_of_string;
  modport source (output valid, output out_byte, output byte_present, output run_last,
                  output end_of_string, input ready);
  modport sink (input valid, input out_byte, input byte_present, input run_last,
                input end_of_string, output ready);
endinterface

FILE: design/esu_parse.sv
// Escape parser: decoder state and the run of result bytes for one input item.
`timescale 1ns / 1ps
module esu_parse import esu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output run_t       run
);

  logic [2:0]  mode_r, mode_nxt, mode_p;
  logic [3:0]  cnt_r, cnt_nxt, cnt_p, cnt_inc, maxd;
  logic [31:0] acc_r, acc_nxt, acc_p, acc_n;
  logic        disc_r, disc_nxt, disc_p;
  logic        flush_en, tail_en, oct_ok, dig_ok;
  logic [31:0] flush_cp;
  logic [7:0]  tail_byte;
  logic [2:0]  fc;
  digit_t      hx;
  pend_t       pd;
  utf8_t       enc;

  always_comb begin
    mode_p    = mode_r;
    cnt_p     = cnt_r;
    acc_p     = acc_r;
    disc_p    = disc_r;
    flush_en  = 1'b0;
    flush_cp  = '0;
    tail_en   = 1'b0;
    tail_byte = in_byte;
    pd        = '0;

    oct_ok  = in_byte >= CH_0 && in_byte <= CH_7;
    hx      = hex_decode(in_byte);
    cnt_inc = cnt_r + 4'd1;
    if (mode_r == MODE_OCT) begin
      maxd    = MAXD_OCT;
      dig_ok  = oct_ok;
      acc_n   = {acc_r[28:0], in_byte[2:0]};
    end else begin
      maxd    = (mode_r == MODE_X) ? MAXD_X : (mode_r == MODE_U4) ? MAXD_U4 : MAXD_U8;
      dig_ok  = hx.ok;
      acc_n   = {acc_r[27:0], hx.val};
    end

    if (!disc_r) begin
      if (mode_r == MODE_ESC) begin
        mode_p = MODE_TEXT;
        cnt_p  = '0;
        acc_p  = '0;
        case (in_byte)
          CH_LC_N: begin tail_en = 1'b1; tail_byte = CTL_LF;  end
          CH_LC_T: begin tail_en = 1'b1; tail_byte = CTL_TAB; end
          CH_LC_R: begin tail_en = 1'b1; tail_byte = CTL_CR;  end
          CH_LC_B: begin tail_en = 1'b1; tail_byte = CTL_BS;  end
          CH_LC_F: begin tail_en = 1'b1; tail_byte = CTL_FF;  end
          CH_LC_V: begin tail_en = 1'b1; tail_byte = CTL_VT;  end
          CH_LC_A: begin tail_en = 1'b1; tail_byte = CTL_BEL; end
          CH_LC_X: mode_p = MODE_X;
          CH_LC_U: mode_p = MODE_U4;
          CH_UC_U: mode_p = MODE_U8;
          CH_NUL:  disc_p = 1'b1;
          default: begin
            if (oct_ok) begin
              mode_p = MODE_OCT;
              acc_p  = {29'd0, in_byte[2:0]};
              cnt_p  = 4'd1;
            end else begin
              tail_en = 1'b1;
            end
          end
        endcase
      end else if (is_numeric(mode_r) && dig_ok && cnt_r < maxd) begin
        if (cnt_inc >= maxd) begin
          flush_en = 1'b1;
          flush_cp = acc_n;
          mode_p   = MODE_TEXT;
          cnt_p    = '0;
          acc_p    = '0;
        end else begin
          acc_p = acc_n;
          cnt_p = cnt_inc;
        end
      end else begin
        if (is_numeric(mode_r)) begin
          pd       = pending_point(mode_r, cnt_r, acc_r);
          flush_en = pd.en;
          flush_cp = pd.cp;
          cnt_p    = '0;
          acc_p    = '0;
        end
        mode_p = MODE_TEXT;
        if (in_byte == CH_NUL) begin
          disc_p = 1'b1;
        end else if (in_byte == CH_BSLASH) begin
          mode_p = MODE_ESC;
        end else begin
          tail_en = 1'b1;
        end
      end
    end

    // end of string flushes a numeric escape still open
    if (in_last && !disc_p && is_numeric(mode_p)) begin
      pd       = pending_point(mode_p, cnt_p, acc_p);
      flush_en = pd.en;
      flush_cp = pd.cp;
    end

    enc = utf8_enc(flush_cp);
    fc  = flush_en ? enc.cnt : 3'd0;
    for (int i = 0; i < RUN_MAX - 1; i++) begin
      run.bytes[i] = (3'(i) < fc) ? enc.bytes[i] : tail_byte;
    end
    run.bytes[RUN_MAX-1] = tail_byte;
    run.cnt  = fc + {2'b00, tail_en};
    run.last = in_last;

    if (in_last) begin
      mode_nxt = MODE_TEXT;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      disc_nxt = 1'b0;
    end else begin
      mode_nxt = mode_p;
      cnt_nxt  = cnt_p;
      acc_nxt  = acc_p;
      disc_nxt = disc_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TEXT;
      cnt_r  <= '0;
      acc_r  <= '0;
      disc_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

FILE: design/esu_emit.sv
// Result register: holds one item's run of bytes and hands them out one per cycle while out_ready is high.
`timescale 1ns / 1ps
module esu_emit import esu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  run_t       run,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_present,
  output logic       run_last,
  output logic       end_of_string
);

  run_t       buf_r;
  logic [2:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic       fin, load;

  always_comb begin
    fin      = (buf_r.cnt == 3'd0) || (idx_r == buf_r.cnt - 3'd1);
    in_ready = !vld_r || (out_ready && fin);
    load     = accept && (run.cnt != 3'd0 || run.last);

    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (accept) begin
      vld_nxt = load;
      idx_nxt = '0;
    end else if (vld_r && out_ready) begin
      if (fin) begin
        vld_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= run;
    end
  end

  assign out_valid     = vld_r;
  assign byte_present  = buf_r.cnt != 3'd0;
  assign out_byte      = byte_present ? buf_r.bytes[idx_r] : 8'h00;
  assign run_last      = fin;
  assign end_of_string = fin && buf_r.last;

endmodule

FILE: design/escape_unescape_to_utf8.sv
// Top level: C escape unescaper with UTF-8 encoding of numeric escapes.
//
//  channel  dir  payload                                           handshake
//  in_ch    in   in_byte[7:0], in_last                             valid/ready
//  out_ch   out  out_byte[7:0], byte_present, run_last,            valid/ready
//                end_of_string
//
// One input item per cycle while in_ready is high; each item leaves 0 to 5 result items,
// one per cycle while out_ready is high. The single result register sets the rate: an item
// with results holds the input until its last result is taken; one with none does not hold it.
// The result is registered and appears in the cycle after the item is accepted.
// rst_n is synchronous, active low; it clears the decoder state and the result register's valid flag and index.
// out_ready low stalls the result register, and the input with it once full.
`timescale 1ns / 1ps
module escape_unescape_to_utf8 import esu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  esu_in_if.sink    in_ch,
  esu_out_if.source out_ch
);

  logic in_ready;
  logic in_acc;
  run_t run;

  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;

  esu_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .in_byte (in_ch.in_byte),
    .in_last (in_ch.in_last),
    .run     (run)
  );

  esu_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_acc),
    .run           (run),
    .in_ready      (in_ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_byte      (out_ch.out_byte),
    .byte_present  (out_ch.byte_present),
    .run_last      (out_ch.run_last),
    .end_of_string (out_ch.end_of_string)
  );

`ifndef SYNTHESIS
  a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.byte_present |-> out_ch.run_last && out_ch.end_of_string)
    else $error("bare result not marked as end of string");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.in_last |=> out_ch.valid)
    else $error("last item produced no result");

  a_no_take_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.run_last |-> !in_ch.ready)
    else $error("input taken while a run is still being sent");
`endif

endmodule
